[hdl/dpfc_pkg.sv]
// ----------------------------------------------------------------------------
// dpfc_pkg
// shared constants and command/status types for the prime factor counter
// ----------------------------------------------------------------------------
package dpfc_pkg;

    localparam int unsigned MaxPrimesDefault  = 65536;
    localparam int unsigned WindowSizeDefault = 131072;

    localparam int unsigned ValueW  = 64;
    localparam int unsigned PrimeW  = 32;
    localparam int unsigned IndexW  = 16;
    localparam int unsigned OffsetW = 17;
    localparam int unsigned PcountW = 17;
    localparam int unsigned CountW  = 4;
    localparam int unsigned CfgW    = 64;
    localparam int unsigned CfgIdxW = 1;

    localparam logic [CountW-1:0] CountMax = 4'd15;

    localparam logic [CfgIdxW-1:0] RegBaseValue  = 1'b0;
    localparam logic [CfgIdxW-1:0] RegPrimeCount = 1'b1;

    localparam logic ActLoad  = 1'b0;
    localparam logic ActCount = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic start;      // capture value, clear count
        logic rd_prime;   // issue table read at walk index
        logic div_start;  // start a division of the value by the read prime
        logic commit;     // take quotient as new value
        logic hit;        // bump count
        logic next_idx;   // advance walk index
        logic finish;     // add remainder hit, load output register
    } dpfc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic value_zero;
        logic value_one;
        logic idx_done;
        logic prime_small;
        logic div_busy;
        logic rem_zero;
    } dpfc_sts_t;

endpackage

[hdl/dpfc_div.sv]
// ----------------------------------------------------------------------------
// dpfc_div
// radix-2 restoring divider, 64-bit dividend by 32-bit divisor
// ----------------------------------------------------------------------------
module dpfc_div
    import dpfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ValueW-1:0] dividend,
    input  logic [PrimeW-1:0] divisor,
    output logic              busy,
    output logic [ValueW-1:0] quotient,
    output logic [PrimeW-1:0] remainder
);

    localparam int unsigned StepW = $clog2(ValueW);

    logic [ValueW-1:0] quot_reg;
    logic [PrimeW:0]   rem_reg;
    logic [PrimeW-1:0] dvs_reg;
    logic [StepW-1:0]  step_reg;
    logic              busy_reg;

    logic [PrimeW:0] shifted;
    logic [PrimeW:0] diff;
    logic            take;

    assign shifted = {rem_reg[PrimeW-1:0], quot_reg[ValueW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign take    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == StepW'(ValueW - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[ValueW-2:0], take};
            rem_reg  <= take ? diff : shifted;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg[PrimeW-1:0];

endmodule

[hdl/dpfc_datapath.sv]
// ----------------------------------------------------------------------------
// dpfc_datapath
// prime table, value and count registers, divider and output register
// ----------------------------------------------------------------------------
module dpfc_datapath
    import dpfc_pkg::*;
#(
    parameter int unsigned MAX_PRIMES = MaxPrimesDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dpfc_cmd_t          cmd,
    output dpfc_sts_t          sts,
    input  logic               tbl_we,
    input  logic [IndexW-1:0]  tbl_idx,
    input  logic [PrimeW-1:0]  tbl_data,
    input  logic [ValueW-1:0]  base_value,
    input  logic [PcountW-1:0] prime_count,
    input  logic [OffsetW-1:0] offset,
    output logic [CountW-1:0]  factor_count,
    output logic [OffsetW-1:0] offset_echo
);

    localparam int unsigned AddrW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
    localparam int unsigned WalkW = $clog2(MAX_PRIMES + 1);

    logic [PrimeW-1:0] table_mem [MAX_PRIMES];
    logic [PrimeW-1:0] prime_reg;

    logic [ValueW-1:0]  value_reg;
    logic [CountW-1:0]  count_reg;
    logic [WalkW-1:0]   walk_reg;
    logic [WalkW-1:0]   limit;
    logic [OffsetW-1:0] off_reg;

    logic              div_busy;
    logic [ValueW-1:0] quotient;
    logic [PrimeW-1:0] remainder;

    logic [CountW-1:0] count_next;

    // clamp prime_count to the table depth
    assign limit = (32'(prime_count) > MAX_PRIMES) ? WalkW'(MAX_PRIMES)
                                                   : WalkW'(prime_count);

    always_ff @(posedge clk)
    begin
        if (tbl_we && (32'(tbl_idx) < MAX_PRIMES))
        begin
            table_mem[AddrW'(tbl_idx)] <= tbl_data;
        end
        if (cmd.rd_prime)
        begin
            prime_reg <= table_mem[walk_reg[AddrW-1:0]];
        end
    end

    dpfc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (value_reg),
        .divisor   (prime_reg),
        .busy      (div_busy),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_comb
    begin
        count_next = count_reg;
        if (count_reg != CountMax)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            value_reg <= base_value + ValueW'(offset);
            off_reg   <= offset;
            count_reg <= '0;
            walk_reg  <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                value_reg <= quotient;
            end
            if (cmd.hit)
            begin
                count_reg <= count_next;
            end
            if (cmd.next_idx)
            begin
                walk_reg <= walk_reg + 1'b1;
            end
        end
        if (cmd.finish)
        begin
            factor_count <= (value_reg > ValueW'(1)) ? count_next : count_reg;
            offset_echo  <= off_reg;
        end
    end

    assign sts.value_zero  = (value_reg == '0);
    assign sts.value_one   = (value_reg == ValueW'(1));
    assign sts.idx_done    = (walk_reg >= limit);
    assign sts.prime_small = (prime_reg < PrimeW'(2));
    assign sts.div_busy    = div_busy;
    assign sts.rem_zero    = (remainder == '0);

endmodule

[hdl/dpfc_ctrl.sv]
// ----------------------------------------------------------------------------
// dpfc_ctrl
// sequencer for the trial division walk and the request handshakes
// ----------------------------------------------------------------------------
module dpfc_ctrl
    import dpfc_pkg::*;
#(
    parameter int unsigned WINDOW_SIZE = WindowSizeDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [OffsetW-1:0] offset,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               tbl_we,
    output dpfc_cmd_t          cmd,
    input  dpfc_sts_t          sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_DIVSTART,
        ST_DIVWAIT,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   found_reg, found_next;
    logic   accept;
    logic   in_window;

    assign in_window = (32'(offset) < WINDOW_SIZE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign tbl_we    = accept && (action == ActLoad);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ActCount) && in_window)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                found_next = 1'b0;
                if (sts.value_zero || sts.value_one || sts.idx_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.rd_prime = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                if (sts.prime_small)
                begin
                    cmd.next_idx = 1'b1;
                    state_next   = ST_CHECK;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVSTART;
                end
            end
            ST_DIVSTART:
            begin
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT:
            begin
                if (!sts.div_busy)
                begin
                    if (sts.rem_zero)
                    begin
                        // divide the quotient again by the same prime
                        cmd.commit = 1'b1;
                        cmd.hit    = !found_reg;
                        found_next = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        cmd.next_idx = 1'b1;
                        state_next   = ST_CHECK;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finish did not raise output valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || !out_stall))
        else $error("stalled result overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider restarted while busy");

endmodule

[hdl/distinct_prime_factor_counter_top.sv]
// ----------------------------------------------------------------------------
// distinct_prime_factor_counter_top
// distinct prime factor counter over a loaded prime table
// ----------------------------------------------------------------------------
// One request at a time. A load request writes one table slot and leaves the
// block ready for the next request. A count request walks the table primes in
// order: each prime read from the table is tested by a shift-subtract divider,
// and the division is repeated on the quotient while the prime divides. A count
// ends early once the value reaches one.
module distinct_prime_factor_counter_top
    import dpfc_pkg::*;
#(
    parameter int unsigned MAX_PRIMES  = MaxPrimesDefault,
    parameter int unsigned WINDOW_SIZE = WindowSizeDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [IndexW-1:0]  prime_index,
    input  logic [PrimeW-1:0]  prime_value,
    input  logic [OffsetW-1:0] offset,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CountW-1:0]  factor_count,
    output logic [OffsetW-1:0] offset_echo
);

    logic [ValueW-1:0]  base_reg;
    logic [PcountW-1:0] pcount_reg;
    logic               tbl_we;
    dpfc_cmd_t          cmd;
    dpfc_sts_t          sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= ValueW'(1);
            pcount_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegBaseValue:  base_reg   <= cfg_data;
                RegPrimeCount: pcount_reg <= cfg_data[PcountW-1:0];
                default:       ;
            endcase
        end
    end

    dpfc_ctrl #(.WINDOW_SIZE(WINDOW_SIZE)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .offset    (offset),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tbl_we    (tbl_we),
        .cmd       (cmd),
        .sts       (sts)
    );

    dpfc_datapath #(.MAX_PRIMES(MAX_PRIMES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .tbl_we       (tbl_we),
        .tbl_idx      (prime_index),
        .tbl_data     (prime_value),
        .base_value   (base_reg),
        .prime_count  (pcount_reg),
        .offset       (offset),
        .factor_count (factor_count),
        .offset_echo  (offset_echo)
    );

endmodule

[tb/sv/tb_distinct_prime_factor_counter_top.sv]
// ----------------------------------------------------------------------------
// tb_distinct_prime_factor_counter_top
// self-checking bench for the distinct prime factor counter
// ----------------------------------------------------------------------------
// Loads prime table slots and issues count requests under random gaps and
// back pressure on both channels. A local trial-division predictor tracks the
// table and both registers and works out each expected count. Only count
// requests whose walk touches written table slots are sent. Results are
// checked in order against the queue of expected counts.
module tb_distinct_prime_factor_counter_top;
    import dpfc_pkg::*;

    localparam int unsigned IdleLimit = 200000;

    typedef struct packed {
        logic [CountW-1:0]  count;
        logic [OffsetW-1:0] offset;
    } count_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgW-1:0]    cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic [IndexW-1:0]  prime_index;
    logic [PrimeW-1:0]  prime_value;
    logic [OffsetW-1:0] offset;
    logic               out_valid;
    logic               out_stall;
    logic [CountW-1:0]  factor_count;
    logic [OffsetW-1:0] offset_echo;

    logic [ValueW-1:0]  base_reg;
    logic [PcountW-1:0] pcount_reg;
    logic [PrimeW-1:0]  table_copy [int unsigned];
    count_result_t      pending_counts [$];

    int errors;
    int idle_cycles;
    int stall_left;
    int hold_off;
    bit quiet_in;
    bit quiet_out;

    int unsigned first_primes [16] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
                                       47, 53};

    distinct_prime_factor_counter_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .prime_index  (prime_index),
        .prime_value  (prime_value),
        .offset       (offset),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .factor_count (factor_count),
        .offset_echo  (offset_echo)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // trial division over the local table copy; walk_ok clears on an unwritten slot
    function automatic logic [CountW-1:0] distinct_factors(input logic [ValueW-1:0] start_val,
                                                           output bit walk_ok);
        logic [ValueW-1:0] v;
        logic [ValueW-1:0] p;
        int unsigned       lim;
        int unsigned       i;
        int                hits;
        v = start_val;
        walk_ok = 1'b1;
        hits = 0;
        if (v == 0)
            return '0;
        lim = (pcount_reg > MaxPrimesDefault) ? MaxPrimesDefault : pcount_reg;
        for (i = 0; i < lim && v != 1; i++)
        begin
            if (!table_copy.exists(i))
            begin
                walk_ok = 1'b0;
                break;
            end
            p = table_copy[i];
            if (p < 2)
                continue;
            if (v % p == 0)
            begin
                if (hits < CountMax)
                    hits++;
                v = v / p;
                while (v % p == 0)
                    v = v / p;
            end
        end
        if (v > 1 && hits < CountMax)
            hits++;
        return hits[CountW-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                   input longint unsigned got_v);
        $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
        errors++;
    endtask

    // result checker, receiver stall draw and watchdog
    always @(posedge clk)
    begin
        count_result_t exp_r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_counts.size() == 0)
                    report_mismatch("unexpected result offset", 0, 64'(offset_echo));
                else
                begin
                    exp_r = pending_counts.pop_front();
                    if (factor_count !== exp_r.count)
                        report_mismatch("factor_count", 64'(exp_r.count), 64'(factor_count));
                    if (offset_echo !== exp_r.offset)
                        report_mismatch("offset_echo", 64'(exp_r.offset), 64'(offset_echo));
                end
                stall_left = quiet_out ? 0 : $urandom_range(0, 9);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver stall driver
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_off - 1) @(negedge clk);
                hold_off = 0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_req(input logic act, input logic [IndexW-1:0] idx,
                            input logic [PrimeW-1:0] pval, input logic [OffsetW-1:0] off);
        int            gap;
        bit            ok;
        count_result_t r;
        gap = quiet_in ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        action      <= act;
        prime_index <= idx;
        prime_value <= pval;
        offset      <= off;
        do @(posedge clk); while (in_stall);
        if (act == ActLoad)
            table_copy[idx] = pval;
        else
        begin
            r.count = distinct_factors(base_reg + ValueW'(off), ok);
            r.offset = off;
            pending_counts.push_back(r);
        end
    endtask

    task automatic load_prime(input logic [IndexW-1:0] idx, input logic [PrimeW-1:0] pval);
        send_req(ActLoad, idx, pval, OffsetW'($urandom));
    endtask

    // returns 0 when the walk would touch an unwritten slot
    task automatic count_at(input logic [OffsetW-1:0] off, output bit sent);
        bit ok;
        void'(distinct_factors(base_reg + ValueW'(off), ok));
        sent = ok;
        if (ok)
            send_req(ActCount, IndexW'($urandom), PrimeW'($urandom), off);
    endtask

    task automatic count_list(input int unsigned offs [$]);
        bit sent;
        foreach (offs[k])
            count_at(OffsetW'(offs[k]), sent);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == RegBaseValue)
            base_reg = data;
        else
            pcount_reg = data[PcountW-1:0];
    endtask

    task automatic test_reset_state();
        count_list('{0, 1, 131071});
    endtask

    task automatic test_table_load();
        foreach (first_primes[k])
            load_prime(IndexW'(k), first_primes[k]);
        load_prime(16, 0);
        load_prime(17, 1);
        load_prime(18, 4);
        load_prime(19, 32'h8000_0000);
        load_prime(16'hFFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_special_values();
        write_reg(RegBaseValue, 0);
        write_reg(RegPrimeCount, 16);
        count_list('{0, 1, 65536, 30030, 131071, 97});
        write_reg(RegPrimeCount, 20);
        count_list('{0, 12, 131070});
        write_reg(RegBaseValue, 64'hFFFF_FFFF_FFFF_FFFF);
        count_list('{0, 1, 131071});
        write_reg(RegBaseValue, 0);
        write_reg(RegPrimeCount, 65536);
        count_list('{1, 1024, 30030});
        write_reg(RegPrimeCount, 17'h1FFFF);
        count_list('{0, 2310, 65536});
    endtask

    // composite entry 4 ahead of 2 adds enough hits to saturate the count at its ceiling
    task automatic test_saturation();
        int unsigned sat_table [16] = '{4, 2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                       43, 47};
        write_reg(RegPrimeCount, 16);
        write_reg(RegBaseValue, 64'd2459559130353965640);
        foreach (sat_table[k])
            load_prime(IndexW'(k), sat_table[k]);
        count_list('{0, 1});
        foreach (first_primes[k])
            load_prime(IndexW'(k), first_primes[k]);
        count_list('{0});
    endtask

    task automatic test_backpressure();
        write_reg(RegBaseValue, 1000);
        quiet_in = 1'b1;
        hold_off = 300;
        repeat (8)
            count_list('{$urandom_range(0, 131071)});
        quiet_in = 1'b0;
        wait_drained();
        count_list('{5, 77});
    endtask

    task automatic random_item();
        bit          sent;
        int unsigned tries;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        sent = 1'b0;
        if (pick < 70)
        begin
            for (tries = 0; tries < 40 && !sent; tries++)
                count_at(OffsetW'($urandom_range(0, 131071)), sent);
        end
        if (!sent)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                load_prime(IndexW'($urandom), PrimeW'($urandom));
            else if (pick < 25)
                load_prime(IndexW'($urandom_range(0, 19)), PrimeW'($urandom));
            else if (pick < 30)
                load_prime(IndexW'($urandom_range(0, 19)), PrimeW'($urandom_range(0, 1)));
            else
                load_prime(IndexW'($urandom_range(0, 19)),
                           first_primes[$urandom_range(0, 15)]);
        end
    endtask

    task automatic test_random();
        logic [CfgW-1:0]    bases [6];
        logic [PcountW-1:0] counts [6];
        bases[0] = 0;
        bases[1] = {$urandom, $urandom};
        bases[2] = 64'hFFFF_FFFF_FFFF_FFFF - CfgW'($urandom_range(0, 131071));
        bases[3] = CfgW'($urandom_range(0, 1000000));
        bases[4] = {$urandom, $urandom};
        bases[5] = 1;
        counts[0] = 17'h1FFFF;
        counts[1] = 16;
        counts[2] = 20;
        counts[3] = 0;
        counts[4] = 1;
        counts[5] = PcountW'($urandom_range(2, 20));
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(RegBaseValue, bases[ph]);
            write_reg(RegPrimeCount, CfgW'(counts[ph]));
            quiet_in = (ph % 2 == 1);
            quiet_out = (ph % 3 == 2);
            repeat (10)
                random_item();
        end
        quiet_in = 1'b0;
        quiet_out = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        action      = ActLoad;
        prime_index = '0;
        prime_value = '0;
        offset      = '0;
        base_reg    = 1;
        pcount_reg  = 0;
        errors      = 0;
        idle_cycles = 0;
        stall_left  = 0;
        hold_off    = 0;
        quiet_in    = 1'b0;
        quiet_out   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_table_load();
        test_special_values();
        test_saturation();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
hdl/dpfc_pkg.sv
hdl/dpfc_div.sv
hdl/dpfc_datapath.sv
hdl/dpfc_ctrl.sv
hdl/distinct_prime_factor_counter_top.sv
tb/sv/tb_distinct_prime_factor_counter_top.sv
